// File: sv/hls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_pkg: shared constants and width helpers for the HLS to RGB converter
// Hue geometry in sixteenths of a degree, field widths and the width rules
// that every pipeline stage derives from the level fraction width.
// ----------------------------------------------------------------------------
package hls_pkg;

    localparam int FIELD_W             = 13;
    localparam int CHAN_W              = 8;
    localparam int LEVEL_FRAC_BITS_DEF = 12;

    localparam int HUE_FULL       = 5760;
    localparam int HUE_THIRD      = 1920;
    localparam int HUE_SIXTH      = 960;
    localparam int HUE_HALF       = 2880;
    localparam int HUE_TWO_THIRDS = 3840;

    // Signed width for hue after the third-turn offsets.
    localparam int HUE_CALC_W = FIELD_W + 2;
    // Ramp position 0..HUE_SIXTH.
    localparam int RAMP_W = 10;

    // 255 / 960 reduces to 17 / 64.
    localparam int RAMP_GAIN_SHIFT = 4;
    localparam int RAMP_DIV_SHIFT  = 6;

    // Signed width of the min(l, 1 - l) term.
    function automatic int k_width(input int frac_bits);
        return (frac_bits + 2 > FIELD_W + 2) ? frac_bits + 2 : FIELD_W + 2;
    endfunction

    // Signed width of k * s.
    function automatic int p_width(input int frac_bits);
        return k_width(frac_bits) + FIELD_W + 1;
    endfunction

    // Signed width of k * s * ramp position.
    function automatic int q_width(input int frac_bits);
        return p_width(frac_bits) + RAMP_W + 1;
    endfunction

    // Unsigned width of 960 * l * 2^F.
    function automatic int l960_width(input int frac_bits);
        return FIELD_W + frac_bits + RAMP_W;
    endfunction

    // Signed width of the ramp level before scaling.
    function automatic int v_width(input int frac_bits);
        return q_width(frac_bits) + 2;
    endfunction

endpackage
`default_nettype wire

// File: sv/hls_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_in_if: input channel of the HLS to RGB converter
// Valid/ready channel carrying one hue, lightness and saturation triple.
// ----------------------------------------------------------------------------
interface hls_in_if;
    logic                         valid;
    logic                         ready;
    logic [hls_pkg::FIELD_W-1:0]  hue;
    logic [hls_pkg::FIELD_W-1:0]  lightness;
    logic [hls_pkg::FIELD_W-1:0]  saturation;

    modport source (output valid, output hue, output lightness, output saturation,
                    input ready);
    modport sink   (input valid, input hue, input lightness, input saturation,
                    output ready);
endinterface
`default_nettype wire

// File: sv/hls_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_out_if: output channel of the HLS to RGB converter
// Valid/ready channel carrying one red, green and blue byte triple.
// ----------------------------------------------------------------------------
interface hls_out_if;
    logic                        valid;
    logic                        ready;
    logic [hls_pkg::CHAN_W-1:0]  red;
    logic [hls_pkg::CHAN_W-1:0]  green;
    logic [hls_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// File: sv/hls_to_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_to_rgb: hue, lightness and saturation to 8-bit RGB converter
// Five-stage pipeline turning one HLS triple into one RGB byte triple.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transfer carries                          Format
//  i_pix    in   hue, lightness, saturation (13 bits each) 1/16 deg, Q(13-F).F, Q(13-F).F
//  o_rgb    out  red, green, blue (8 bits each)            unsigned byte
//
//  One transfer is taken every clock while o_rgb is not stalled; a result
//  passes through the five register stages front, k*s product, ramp
//  products, level sum and byte scaling.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage advances when it is empty or the next stage advances, so a
//  stall on o_rgb holds every item in place and empty stages still fill.
//
//  With m2 = L + k*s and m1 = L - k*s (k = min(l, 1 - l), L = l * 2^F), the
//  ramp of a channel is 960*m1 + 2*k*s*t, where t runs 0..960 along the
//  rising edge, stays at 960 on the flat top and falls back on the other
//  side. Because 255/960 equals 17/64, the byte is that level times 17
//  shifted right by 2F+6, so the gray case needs no separate path: a zero
//  saturation makes every level 960*L and gives floor(255*l / 2^F).
//
module hls_to_rgb #(
    parameter int LEVEL_FRAC_BITS = hls_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hls_in_if.sink    i_pix,
    hls_out_if.source o_rgb
);

    localparam int KW = hls_pkg::k_width(LEVEL_FRAC_BITS);
    localparam int QW = hls_pkg::q_width(LEVEL_FRAC_BITS);
    localparam int LW = hls_pkg::l960_width(LEVEL_FRAC_BITS);
    localparam int RW = hls_pkg::RAMP_W;

    // Front stage to product stages.
    logic                        f_valid;
    logic                        f_ready;
    logic signed [KW-1:0]        f_k;
    logic [hls_pkg::FIELD_W-1:0] f_l;
    logic [hls_pkg::FIELD_W-1:0] f_s;
    logic [2:0][RW-1:0]          f_t;

    // Product stages to ramp stages.
    logic                        m_valid;
    logic                        m_ready;
    logic [2:0][QW-1:0]          m_q;
    logic [LW-1:0]               m_l960;

    hls_front #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .o_valid      (f_valid),
        .i_ready      (f_ready),
        .o_k          (f_k),
        .o_lightness  (f_l),
        .o_saturation (f_s),
        .o_t          (f_t)
    );

    hls_mult #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (f_valid),
        .o_ready      (f_ready),
        .i_k          (f_k),
        .i_lightness  (f_l),
        .i_saturation (f_s),
        .i_t          (f_t),
        .o_valid      (m_valid),
        .i_ready      (m_ready),
        .o_q          (m_q),
        .o_l960       (m_l960)
    );

    hls_ramp #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (m_ready),
        .i_q     (m_q),
        .i_l960  (m_l960),
        .o_rgb   (o_rgb)
    );

endmodule
`default_nettype wire

// File: sv/hls_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_front: first pipeline stage
// Works out min(l, 1 - l) and the ramp position of each of the three hues.
// ----------------------------------------------------------------------------
module hls_front #(
    parameter int  LEVEL_FRAC_BITS = hls_pkg::LEVEL_FRAC_BITS_DEF,
    localparam int KW              = hls_pkg::k_width(LEVEL_FRAC_BITS)
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    hls_in_if.sink                                         i_pix,
    output logic                                           o_valid,
    input  wire logic                                      i_ready,
    output logic signed [KW-1:0]                           o_k,
    output logic [hls_pkg::FIELD_W-1:0]                    o_lightness,
    output logic [hls_pkg::FIELD_W-1:0]                    o_saturation,
    output logic [2:0][hls_pkg::RAMP_W-1:0]                o_t
);

    localparam int HW = hls_pkg::HUE_CALC_W;
    localparam int RW = hls_pkg::RAMP_W;

    localparam logic signed [KW-1:0] C_ONE  = KW'(1) << LEVEL_FRAC_BITS;
    localparam logic signed [KW-1:0] C_HALF = KW'(1) << (LEVEL_FRAC_BITS - 1);

    localparam logic signed [HW-1:0] C_FULL       = HW'(hls_pkg::HUE_FULL);
    localparam logic signed [HW-1:0] C_THIRD      = HW'(hls_pkg::HUE_THIRD);
    localparam logic signed [HW-1:0] C_SIXTH      = HW'(hls_pkg::HUE_SIXTH);
    localparam logic signed [HW-1:0] C_HALF_TURN  = HW'(hls_pkg::HUE_HALF);
    localparam logic signed [HW-1:0] C_TWO_THIRDS = HW'(hls_pkg::HUE_TWO_THIRDS);

    // Wrap once into 0..HUE_FULL-1 and fold onto the rising, flat and falling
    // parts of the ramp; the result is how far the level sits from m1.
    function automatic logic [RW-1:0] ramp_pos(input logic signed [HW-1:0] a);
        logic signed [HW-1:0] w;
        logic signed [HW-1:0] d;
        w = a;
        if (w >= C_FULL) begin
            w = w - C_FULL;
        end else if (w < 0) begin
            w = w + C_FULL;
        end
        d = C_TWO_THIRDS - w;
        if (w < C_SIXTH) begin
            ramp_pos = RW'(w);
        end else if (w < C_HALF_TURN) begin
            ramp_pos = RW'(C_SIXTH);
        end else if (w < C_TWO_THIRDS) begin
            ramp_pos = RW'(d);
        end else begin
            ramp_pos = '0;
        end
    endfunction

    logic                        en;
    logic                        r_valid;
    logic signed [KW-1:0]        l_ext;
    logic signed [HW-1:0]        h_s;
    logic signed [KW-1:0]        n_k;
    logic [2:0][RW-1:0]          n_t;
    logic signed [KW-1:0]        r_k;
    logic [hls_pkg::FIELD_W-1:0] r_l;
    logic [hls_pkg::FIELD_W-1:0] r_s;
    logic [2:0][RW-1:0]          r_t;

    assign en          = !r_valid || i_ready;
    assign i_pix.ready = en;

    assign l_ext = $signed(KW'(i_pix.lightness));
    assign n_k   = (l_ext <= C_HALF) ? l_ext : (C_ONE - l_ext);

    assign h_s    = $signed(HW'(i_pix.hue));
    assign n_t[0] = ramp_pos(h_s + C_THIRD);
    assign n_t[1] = ramp_pos(h_s);
    assign n_t[2] = ramp_pos(h_s - C_THIRD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_pix.valid) begin
            r_k <= n_k;
            r_l <= i_pix.lightness;
            r_s <= i_pix.saturation;
            r_t <= n_t;
        end
    end

    assign o_valid      = r_valid;
    assign o_k          = r_k;
    assign o_lightness  = r_l;
    assign o_saturation = r_s;
    assign o_t          = r_t;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_k <= C_HALF))
        else $error("min term above one half");

    a_t_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_t[0] <= RW'(hls_pkg::HUE_SIXTH) && r_t[1] <= RW'(hls_pkg::HUE_SIXTH)
                     && r_t[2] <= RW'(hls_pkg::HUE_SIXTH)))
        else $error("ramp position beyond one sixth turn");

endmodule
`default_nettype wire

// File: sv/hls_mult.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_mult: second and third pipeline stages
// Forms k * s, then the three ramp products and the scaled lightness term.
// ----------------------------------------------------------------------------
module hls_mult #(
    parameter int  LEVEL_FRAC_BITS = hls_pkg::LEVEL_FRAC_BITS_DEF,
    localparam int KW              = hls_pkg::k_width(LEVEL_FRAC_BITS),
    localparam int QW              = hls_pkg::q_width(LEVEL_FRAC_BITS),
    localparam int LW              = hls_pkg::l960_width(LEVEL_FRAC_BITS)
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic signed [KW-1:0]                   i_k,
    input  wire logic [hls_pkg::FIELD_W-1:0]            i_lightness,
    input  wire logic [hls_pkg::FIELD_W-1:0]            i_saturation,
    input  wire logic [2:0][hls_pkg::RAMP_W-1:0]        i_t,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [2:0][QW-1:0]                          o_q,
    output logic [LW-1:0]                               o_l960
);

    localparam int PW = hls_pkg::p_width(LEVEL_FRAC_BITS);
    localparam int RW = hls_pkg::RAMP_W;
    localparam int TW = RW + 1;

    // Half of the ramp span; centring t on it folds the -960*k*s part of
    // 960*m1 into the product, so the lightness term alone is the base.
    localparam logic signed [TW-1:0] C_MID = TW'(hls_pkg::HUE_SIXTH / 2);

    logic                        en_a;
    logic                        en_b;
    logic                        r_valid_a;
    logic                        r_valid_b;
    logic signed [PW-1:0]        n_p;
    logic signed [PW-1:0]        r_p;
    logic [hls_pkg::FIELD_W-1:0] r_l;
    logic [2:0][RW-1:0]          r_t;
    logic [2:0][QW-1:0]          n_q;
    logic [LW-1:0]               l_wide;
    logic [LW-1:0]               n_l960;
    logic [2:0][QW-1:0]          r_q;
    logic [LW-1:0]               r_l960;

    assign en_b    = !r_valid_b || i_ready;
    assign en_a    = !r_valid_a || en_b;
    assign o_ready = en_a;

    assign n_p = PW'(i_k) * PW'($signed({1'b0, i_saturation}));

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic signed [TW-1:0] t_c;
        assign t_c    = $signed({1'b0, r_t[i]}) - C_MID;
        assign n_q[i] = QW'(r_p) * QW'(t_c);
    end

    // 960 = 1024 - 64, with the lightness already scaled by 2^F.
    assign l_wide = LW'(r_l);
    assign n_l960 = (l_wide << (LEVEL_FRAC_BITS + 10)) - (l_wide << (LEVEL_FRAC_BITS + 6));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (en_a) begin
                r_valid_a <= i_valid;
            end
            if (en_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_p <= n_p;
            r_l <= i_lightness;
            r_t <= i_t;
        end
        if (en_b && r_valid_a) begin
            r_q    <= n_q;
            r_l960 <= n_l960;
        end
    end

    assign o_valid = r_valid_b;
    assign o_q     = r_q;
    assign o_l960  = r_l960;

endmodule
`default_nettype wire

// File: sv/hls_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hls_ramp: fourth and fifth pipeline stages
// Sums the ramp level of each channel, scales it to a byte and clamps it.
// ----------------------------------------------------------------------------
module hls_ramp #(
    parameter int  LEVEL_FRAC_BITS = hls_pkg::LEVEL_FRAC_BITS_DEF,
    localparam int QW              = hls_pkg::q_width(LEVEL_FRAC_BITS),
    localparam int LW              = hls_pkg::l960_width(LEVEL_FRAC_BITS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [2:0][QW-1:0]    i_q,
    input  wire logic [LW-1:0]         i_l960,
    hls_out_if.source                  o_rgb
);

    localparam int VW = hls_pkg::v_width(LEVEL_FRAC_BITS);
    localparam int GW = VW + hls_pkg::RAMP_GAIN_SHIFT + 1;
    localparam int SH = 2 * LEVEL_FRAC_BITS + hls_pkg::RAMP_DIV_SHIFT;
    localparam int CW = hls_pkg::CHAN_W;

    // Level * 17 / 2^(2F+6), floored; zero or below gives 0, overflow 255.
    function automatic logic [CW-1:0] chan_byte(input logic signed [VW-1:0] v);
        logic signed [GW-1:0] g;
        logic signed [GW-1:0] q;
        g = (GW'(v) <<< hls_pkg::RAMP_GAIN_SHIFT) + GW'(v);
        q = g >>> SH;
        if (v <= 0) begin
            chan_byte = '0;
        end else if (|q[GW-1:CW]) begin
            chan_byte = '1;
        end else begin
            chan_byte = q[CW-1:0];
        end
    endfunction

    logic                         en_c;
    logic                         en_d;
    logic                         r_valid_c;
    logic                         r_valid_d;
    logic signed [VW-1:0]         base;
    logic [2:0][VW-1:0]           n_v;
    logic signed [2:0][VW-1:0]    r_v;
    logic [CW-1:0]                r_red;
    logic [CW-1:0]                r_grn;
    logic [CW-1:0]                r_blu;

    assign en_d    = !r_valid_d || o_rgb.ready;
    assign en_c    = !r_valid_c || en_d;
    assign o_ready = en_c;

    assign base = $signed(VW'(i_l960));

    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign n_v[i] = base + (VW'($signed(i_q[i])) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
        end else begin
            if (en_c) begin
                r_valid_c <= i_valid;
            end
            if (en_d) begin
                r_valid_d <= r_valid_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && i_valid) begin
            r_v <= n_v;
        end
        if (en_d && r_valid_c) begin
            r_red <= chan_byte(r_v[0]);
            r_grn <= chan_byte(r_v[1]);
            r_blu <= chan_byte(r_v[2]);
        end
    end

    assign o_rgb.valid = r_valid_d;
    assign o_rgb.red   = r_red;
    assign o_rgb.green = r_grn;
    assign o_rgb.blue  = r_blu;

    a_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_c && en_d && $signed(r_v[0]) <= 0) |=> (r_red == '0))
        else $error("non-positive red level gave a non-zero byte");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_c && en_d && r_v[0] == r_v[1] && r_v[1] == r_v[2])
        |=> (r_red == r_grn && r_grn == r_blu))
        else $error("equal levels gave unequal bytes");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_d && r_valid_c && !o_rgb.ready) |=> r_valid_c)
        else $error("level stage moved while the output stalled");

endmodule
`default_nettype wire

// File: tb/sv/tb_hls_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hls_to_rgb: self-checking testbench for the HLS to RGB converter
// Drives hue, lightness and saturation triples through the input channel,
// predicts every colour with its own fixed-point model and compares each
// output transfer with the oldest prediction, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_hls_to_rgb;

    localparam int FW = hls_pkg::FIELD_W;
    localparam int CW = hls_pkg::CHAN_W;
    // Level fraction width used by both the block and the colour predictor.
    localparam int FRAC = hls_pkg::LEVEL_FRAC_BITS_DEF;
    // The pipeline is five stages deep; this margin covers it several times.
    localparam int DRAIN_CYCLES = 20;
    // Generous ceiling on the whole run, far above the slowest correct run.
    localparam longint RUN_LIMIT_NS = 2_000_000;
    // Cycles for which the output side refuses transfers in the hold-off test.
    localparam int HOLD_CYCLES = 200;
    // Mismatch lines beyond this are counted but not printed.
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [FW-1:0] hue;
        logic [FW-1:0] lightness;
        logic [FW-1:0] saturation;
    } t_hls_px;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } t_rgb;

    // One accepted pixel together with the colour it must produce.
    typedef struct packed {
        t_hls_px px;
        t_rgb    rgb;
    } t_colour_due;

    logic clk;
    logic rst_n;

    hls_in_if  pix_if ();
    hls_out_if rgb_if ();

    hls_to_rgb #(
        .LEVEL_FRAC_BITS(FRAC)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_pix  (pix_if),
        .o_rgb  (rgb_if)
    );

    // Colours still owed by the block, oldest first.
    t_colour_due colour_due_q[$];

    int mismatches;
    int pixels_sent;
    int colours_checked;
    int sender_idle_pct;
    int stall_pct;
    int hold_left;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A hung handshake or a lost colour ends up here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Colour predictor
    // ------------------------------------------------------------------------

    // Brings a hue offset by a third of a turn back into one full turn. A
    // single correction is always enough for a 13-bit hue.
    function automatic longint wrap_angle(input longint a);
        if (a >= hls_pkg::HUE_FULL) begin
            return a - hls_pkg::HUE_FULL;
        end else if (a < 0) begin
            return a + hls_pkg::HUE_FULL;
        end
        return a;
    endfunction

    // Evaluates the piecewise-linear HLS ramp between the low and high
    // levels (both in Q(2F)) at one hue, then scales by 255, floors and
    // clamps. The division is exact up to that final floor.
    function automatic logic [CW-1:0] ramp_to_byte(input longint lo, input longint hi,
                                                  input longint h);
        longint level;
        longint scaled;
        longint denom;
        longint q;
        denom = longint'(hls_pkg::HUE_SIXTH) << (2 * FRAC);
        if (h < hls_pkg::HUE_SIXTH) begin
            level = lo * hls_pkg::HUE_SIXTH + (hi - lo) * h;
        end else if (h < hls_pkg::HUE_HALF) begin
            level = hi * hls_pkg::HUE_SIXTH;
        end else if (h < hls_pkg::HUE_TWO_THIRDS) begin
            level = lo * hls_pkg::HUE_SIXTH + (hi - lo) * (hls_pkg::HUE_TWO_THIRDS - h);
        end else begin
            level = lo * hls_pkg::HUE_SIXTH;
        end
        scaled = level * 255;
        if (scaled <= 0) begin
            return '0;
        end
        q = scaled / denom;
        if (q > 255) begin
            q = 255;
        end
        return q[CW-1:0];
    endfunction

    function automatic t_rgb predict_rgb(input t_hls_px px);
        longint one_q;
        longint h;
        longint l;
        longint s;
        longint k;
        longint m1;
        longint m2;
        longint grey;
        t_rgb   c;
        one_q = longint'(1) << FRAC;
        h     = longint'(px.hue);
        l     = longint'(px.lightness);
        s     = longint'(px.saturation);
        if (s == 0) begin
            // Zero saturation is plain grey at the lightness level.
            grey = (l * 255) >>> FRAC;
            if (grey > 255) begin
                grey = 255;
            end
            c.red   = grey[CW-1:0];
            c.green = grey[CW-1:0];
            c.blue  = grey[CW-1:0];
            return c;
        end
        // Below or at one half the spread follows the lightness, above it the
        // distance to white; past 1.0 that distance turns negative.
        k  = (2 * l <= one_q) ? l : (one_q - l);
        m2 = l * one_q + k * s;
        m1 = 2 * l * one_q - m2;
        c.red   = ramp_to_byte(m1, m2, wrap_angle(h + hls_pkg::HUE_THIRD));
        c.green = ramp_to_byte(m1, m2, wrap_angle(h));
        c.blue  = ramp_to_byte(m1, m2, wrap_angle(h - hls_pkg::HUE_THIRD));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    // Every output transfer is matched against the oldest colour owed.
    always @(posedge clk) begin : colour_check
        t_colour_due due;
        if (rst_n && rgb_if.valid && rgb_if.ready) begin
            if (colour_due_q.size() == 0) begin
                report_mismatch($sformatf("colour with none owed: r=%0d g=%0d b=%0d",
                                          rgb_if.red, rgb_if.green, rgb_if.blue));
            end else begin
                due = colour_due_q.pop_front();
                colours_checked++;
                if (rgb_if.red !== due.rgb.red || rgb_if.green !== due.rgb.green
                        || rgb_if.blue !== due.rgb.blue) begin
                    report_mismatch($sformatf(
                        "h=%0d l=%0d s=%0d: rgb got %0d/%0d/%0d want %0d/%0d/%0d",
                        due.px.hue, due.px.lightness, due.px.saturation,
                        rgb_if.red, rgb_if.green, rgb_if.blue,
                        due.rgb.red, due.rgb.green, due.rgb.blue));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: ready is driven at the falling edge. A pending hold-off is
    // counted down here and overrides the random stalling while it lasts.
    // ------------------------------------------------------------------------
    initial begin
        rgb_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rgb_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rgb_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one pixel, after a random run of idle cycles, and holds it until
    // the transfer happens. The expected colour is queued at that very edge.
    task automatic send_pixel(input t_hls_px px);
        t_colour_due entry;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            pix_if.valid      <= 1'b0;
            pix_if.hue        <= FW'($urandom);
            pix_if.lightness  <= FW'($urandom);
            pix_if.saturation <= FW'($urandom);
        end
        @(negedge clk);
        pix_if.valid      <= 1'b1;
        pix_if.hue        <= px.hue;
        pix_if.lightness  <= px.lightness;
        pix_if.saturation <= px.saturation;
        do begin
            @(posedge clk);
        end while (!pix_if.ready);
        entry.px     = px;
        entry.rgb    = predict_rgb(px);
        colour_due_q = {colour_due_q, entry};
        pixels_sent++;
    endtask

    function automatic t_hls_px mk_px(input int h, input int l, input int s);
        t_hls_px px;
        px.hue        = FW'(h);
        px.lightness  = FW'(l);
        px.saturation = FW'(s);
        return px;
    endfunction

    // Mostly ordinary colours, with a share of greys, of values on the ramp
    // corners and the one-half lightness split, and of fully random 13-bit
    // fields that push hue past a full turn and the levels past 1.0.
    function automatic t_hls_px random_pixel();
        int sel;
        int hue_pts[12] = '{0, 1, 959, 960, 961, 1919, 1920, 2879, 2880, 3839, 3840, 5759};
        int lvl_pts[8]  = '{0, 1, 2047, 2048, 2049, 4095, 4096, 8191};
        sel = $urandom_range(99);
        if (sel < 60) begin
            return mk_px($urandom_range(hls_pkg::HUE_FULL - 1), $urandom_range(4096),
                         $urandom_range(4096, 1));
        end else if (sel < 70) begin
            return mk_px($urandom_range(8191), $urandom_range(4096), 0);
        end else if (sel < 82) begin
            return mk_px(hue_pts[$urandom_range(11)], lvl_pts[$urandom_range(7)],
                         lvl_pts[$urandom_range(7)]);
        end
        return mk_px($urandom_range(8191), $urandom_range(8191), $urandom_range(8191));
    endfunction

    task automatic send_random_pixels(input int count);
        repeat (count) begin
            send_pixel(random_pixel());
        end
    endtask

    // Drops valid, waits until every owed colour has arrived, then lets the
    // pipeline run empty so that a stray extra colour would still be caught.
    task automatic wait_for_colours();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (colour_due_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Greys, the primaries, every ramp corner, the hue wrap above a full
    // turn, the lightness split at one half and levels above 1.0.
    task automatic test_corner_cases();
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_pixel(mk_px(0, 0, 0));
        send_pixel(mk_px(0, 4096, 0));
        send_pixel(mk_px(100, 2048, 0));
        send_pixel(mk_px(8191, 8191, 0));
        send_pixel(mk_px(0, 2048, 4096));
        send_pixel(mk_px(hls_pkg::HUE_THIRD, 2048, 4096));
        send_pixel(mk_px(hls_pkg::HUE_TWO_THIRDS, 2048, 4096));
        send_pixel(mk_px(hls_pkg::HUE_SIXTH - 1, 2048, 4096));
        send_pixel(mk_px(hls_pkg::HUE_SIXTH, 2047, 4096));
        send_pixel(mk_px(hls_pkg::HUE_HALF - 1, 2049, 4096));
        send_pixel(mk_px(hls_pkg::HUE_HALF, 1024, 2048));
        send_pixel(mk_px(hls_pkg::HUE_TWO_THIRDS - 1, 3072, 4095));
        send_pixel(mk_px(hls_pkg::HUE_FULL - 1, 2048, 4096));
        send_pixel(mk_px(hls_pkg::HUE_FULL, 2048, 4096));
        send_pixel(mk_px(8191, 2048, 4096));
        send_pixel(mk_px(4000, 4096, 4096));
        send_pixel(mk_px(500, 6000, 3000));
        send_pixel(mk_px(700, 8191, 8191));
        send_pixel(mk_px(1500, 3000, 8191));
        send_pixel(mk_px(2000, 1, 1));
        send_pixel(mk_px(300, 2048, 1));
        send_pixel(mk_px(6000, 100, 8191));
        send_pixel(mk_px(0, 0, 4096));
        send_pixel(mk_px(1234, 4095, 4096));
        wait_for_colours();
    endtask

    task automatic test_streaming();
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_random_pixels(130);
        wait_for_colours();
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct = 67;
        stall_pct       = 0;
        send_random_pixels(130);
        wait_for_colours();
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct = 0;
        stall_pct       = 67;
        send_random_pixels(130);
        wait_for_colours();
    endtask

    task automatic test_mixed_idling();
        sender_idle_pct = 12;
        stall_pct       = 12;
        send_random_pixels(130);
        wait_for_colours();
    endtask

    // The output refuses everything for a long stretch while pixels keep
    // coming, so the pipeline fills and the input has to stall.
    task automatic test_output_hold();
        sender_idle_pct = 0;
        stall_pct       = 0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        send_random_pixels(60);
        wait_for_colours();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatches        = 0;
        pixels_sent       = 0;
        colours_checked   = 0;
        sender_idle_pct   = 0;
        stall_pct         = 0;
        hold_left         = 0;
        rst_n             = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.hue        = '0;
        pix_if.lightness  = '0;
        pix_if.saturation = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_hold();

        $display("summary: %0d pixels sent, %0d colours checked, %0d mismatches",
                 pixels_sent, colours_checked, mismatches);
        $display("summary: greys, ramp corners, hue wrap, over-range levels, idle gaps, ",
                 "output stalls and a long output hold-off");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
